>>> hdl/rsd_pkg.sv
// Shared types, constants and register indexes of the radio sub-packet deframer.
package rsd_pkg;

   localparam int NumSlotsDef = 4;
   localparam int MaxFrameDef = 32;

   localparam int ByteW  = 8;
   localparam int FlenW  = 6;
   localparam int PosW   = 5;
   localparam int CsrIdxW = 3;

   localparam logic [ByteW-1:0] PadLow  = 8'h00;
   localparam logic [ByteW-1:0] PadHigh = 8'hFF;

   localparam logic [CsrIdxW-1:0] CSR_SLOT0       = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_UNKNOWN_EN  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_CATCHALL_EN = 3'd5;

   typedef enum logic [1:0] {
      PH_ID   = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_DROP    = 2'd2
   } kind_type;

   typedef struct packed {
      logic unknown_en;
      logic catchall_en;
   } cfg_type;

   typedef struct packed {
      kind_type         kind;
      logic [ByteW-1:0] prog_id;
      logic [PosW-1:0]  payload_len;
      logic [ByteW-1:0] payload_byte;
      logic [PosW-1:0]  byte_index;
      logic             last_of_packet;
      logic             registered_hit;
      logic [1:0]       hit_slot;
      logic             to_unknown;
      logic             to_catchall;
   } result_type;

endpackage

>>> hdl/rsd_csr.sv
// Configuration registers: registered slot IDs and consumer enables.
module rsd_csr #(
   parameter int NUM_SLOTS = rsd_pkg::NumSlotsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [rsd_pkg::CsrIdxW-1:0]   wr_index,
   input  logic [rsd_pkg::ByteW-1:0]     wr_data,
   output logic [rsd_pkg::ByteW-1:0]     slot_ids [NUM_SLOTS],
   output rsd_pkg::cfg_type              cfg
);
   import rsd_pkg::*;

   logic [ByteW-1:0] slot_ff [NUM_SLOTS];
   logic [ByteW-1:0] slot_in [NUM_SLOTS];
   cfg_type          cfg_ff;
   cfg_type          cfg_in;

   always_comb begin
      slot_in = slot_ff;
      cfg_in  = cfg_ff;
      if (wr_en) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (wr_index == CSR_SLOT0 + CsrIdxW'(i)) begin
               slot_in[i] = wr_data;
            end
         end
         unique case (wr_index)
            CSR_UNKNOWN_EN:  cfg_in.unknown_en  = wr_data[0];
            CSR_CATCHALL_EN: cfg_in.catchall_en = wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= PadHigh;
         end
         cfg_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         cfg_ff  <= cfg_in;
      end
   end

   assign slot_ids = slot_ff;
   assign cfg      = cfg_ff;

endmodule

>>> hdl/rsd_slot_match.sv
// Compares a program ID against the registered slots and picks the lowest hit.
module rsd_slot_match #(
   parameter int NUM_SLOTS = rsd_pkg::NumSlotsDef
) (
   input  logic [rsd_pkg::ByteW-1:0] prog_id,
   input  logic [rsd_pkg::ByteW-1:0] slot_ids [NUM_SLOTS],
   output logic                      hit,
   output logic [1:0]                slot
);
   import rsd_pkg::*;

   always_comb begin
      hit  = 1'b0;
      slot = 2'd0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (slot_ids[i] != PadLow && slot_ids[i] != PadHigh && slot_ids[i] == prog_id) begin
            hit  = 1'b1;
            slot = 2'(i);
         end
      end
   end

endmodule

>>> hdl/rsd_parser.sv
// Frame parser: parse state registers and the per-byte next-state and result logic.
module rsd_parser #(
   parameter int NUM_SLOTS = rsd_pkg::NumSlotsDef,
   parameter int MAX_FRAME = rsd_pkg::MaxFrameDef
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [rsd_pkg::ByteW-1:0] rx_byte,
   input  logic                      frame_start,
   input  logic [rsd_pkg::FlenW-1:0] frame_len,
   input  rsd_pkg::cfg_type          cfg,
   input  logic [rsd_pkg::ByteW-1:0] slot_ids [NUM_SLOTS],
   output logic                      res_valid,
   output rsd_pkg::result_type       res
);
   import rsd_pkg::*;

   localparam logic [FlenW-1:0] MaxFrameC = FlenW'(MAX_FRAME);

   phase_type        phase_ff, phase_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [ByteW-1:0] id_ff, id_in;
   logic [PosW-1:0]  len_ff, len_in;
   logic [PosW-1:0]  count_ff, count_in;
   logic             drop_ff, drop_in;

   phase_type        ph_cur;
   logic [PosW-1:0]  pos_cur;
   logic             drop_cur;
   logic [FlenW-1:0] flen;
   logic [FlenW-1:0] pos_ext;
   logic [FlenW-1:0] pos_next;
   logic [8:0]       len_end;
   logic             last;
   logic             flags;
   logic             hit;
   logic [1:0]       slot;

   assign flen     = (frame_len > MaxFrameC) ? MaxFrameC : frame_len;
   assign ph_cur   = frame_start ? PH_ID : phase_ff;
   assign pos_cur  = frame_start ? '0 : pos_ff;
   assign drop_cur = frame_start ? 1'b0 : drop_ff;
   assign pos_ext  = {1'b0, pos_cur};
   assign pos_next = pos_ext + FlenW'(1);
   assign len_end  = 9'(pos_cur) + 9'(rx_byte);
   assign last     = (FlenW'(count_ff) + FlenW'(1)) == FlenW'(len_ff);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      drop_in   = drop_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      res_valid = 1'b0;
      flags     = 1'b0;
      res       = '0;
      res.kind    = KIND_PAYLOAD;
      res.prog_id = id_ff;
      if (step) begin
         phase_in = ph_cur;
         pos_in   = pos_cur;
         drop_in  = drop_cur;
         if (!drop_cur) begin
            if (pos_ext >= flen) begin
               drop_in = 1'b1;
            end else begin
               unique case (ph_cur)
                  PH_LEN: begin
                     if (len_end < 9'(flen)) begin
                        if (rx_byte == PadLow) begin
                           res_valid          = 1'b1;
                           flags              = 1'b1;
                           res.kind           = KIND_EMPTY;
                           res.last_of_packet = 1'b1;
                           phase_in           = PH_ID;
                        end else begin
                           len_in   = rx_byte[PosW-1:0];
                           count_in = '0;
                           phase_in = PH_DATA;
                        end
                     end else begin
                        res_valid = 1'b1;
                        res.kind  = KIND_DROP;
                        drop_in   = 1'b1;
                     end
                  end
                  PH_DATA: begin
                     res_valid          = 1'b1;
                     flags              = 1'b1;
                     res.kind           = KIND_PAYLOAD;
                     res.payload_len    = len_ff;
                     res.payload_byte   = rx_byte;
                     res.byte_index     = count_ff;
                     res.last_of_packet = last;
                     count_in           = count_ff + PosW'(1);
                     if (last) begin
                        phase_in = PH_ID;
                     end
                  end
                  default: begin
                     phase_in = PH_ID;
                     if (rx_byte != PadLow && rx_byte != PadHigh) begin
                        if (pos_next >= flen) begin
                           res_valid   = 1'b1;
                           res.kind    = KIND_DROP;
                           res.prog_id = rx_byte;
                           drop_in     = 1'b1;
                        end else begin
                           id_in    = rx_byte;
                           phase_in = PH_LEN;
                        end
                     end
                  end
               endcase
               if (pos_next >= flen) begin
                  drop_in = 1'b1;
               end
               pos_in = pos_next[PosW-1:0];
            end
         end
         res.registered_hit = flags & hit;
         res.hit_slot       = (flags & hit) ? slot : 2'd0;
         res.to_unknown     = flags & ~hit & cfg.unknown_en;
         res.to_catchall    = flags & cfg.catchall_en;
      end
   end

   rsd_slot_match #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_match (
      .prog_id (id_ff),
      .slot_ids(slot_ids),
      .hit     (hit),
      .slot    (slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ID;
         pos_ff   <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

>>> hdl/radio_subpacket_deframer.sv
// Radio sub-packet deframer top level: input register, parser and result register.
// The block takes one frame byte per clock cycle unless the result channel stalls it, and
// gives at most one result per byte. A byte is held in an input register, parsed and
// matched against the slot table combinationally, and its result is held in a result
// register, which drives the result channel. The input side keeps taking bytes while a
// result waits, as long as the input register is empty or the result register is free or
// is being emptied in the same cycle. Configuration writes are taken in every cycle and
// must only be made while the block is idle.
module radio_subpacket_deframer #(
   parameter int NUM_SLOTS = rsd_pkg::NumSlotsDef,
   parameter int MAX_FRAME = rsd_pkg::MaxFrameDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        req_frame_start,
   input  logic [5:0]                  req_frame_len,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [7:0]                  rsp_prog_id,
   output logic [4:0]                  rsp_payload_len,
   output logic [7:0]                  rsp_payload_byte,
   output logic [4:0]                  rsp_byte_index,
   output logic                        rsp_last_of_packet,
   output logic                        rsp_registered_hit,
   output logic [1:0]                  rsp_hit_slot,
   output logic                        rsp_to_unknown,
   output logic                        rsp_to_catchall,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rsd_pkg::CsrIdxW-1:0] csr_index,
   input  logic [7:0]                  csr_wdata
);
   import rsd_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [ByteW-1:0] in_byte_ff;
   logic             in_start_ff;
   logic [FlenW-1:0] in_len_ff;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff;
   logic             advance;
   logic             req_take;
   logic             par_valid;
   result_type       par_res;
   cfg_type          cfg;
   logic [ByteW-1:0] slot_ids [NUM_SLOTS];

   assign advance     = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready   = ~in_valid_ff | advance;
   assign req_take    = req_valid & req_ready;
   assign in_valid_in = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance ? par_valid : (out_valid_ff & ~rsp_ready);
   assign csr_ready   = 1'b1;

   rsd_csr #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_valid),
      .wr_index(csr_index),
      .wr_data (csr_wdata),
      .slot_ids(slot_ids),
      .cfg     (cfg)
   );

   rsd_parser #(
      .NUM_SLOTS(NUM_SLOTS),
      .MAX_FRAME(MAX_FRAME)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .frame_start(in_start_ff),
      .frame_len  (in_len_ff),
      .cfg        (cfg),
      .slot_ids   (slot_ids),
      .res_valid  (par_valid),
      .res        (par_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
         in_len_ff   <= req_frame_len;
      end
      if (advance && par_valid) begin
         out_ff <= par_res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_prog_id        = out_ff.prog_id;
   assign rsp_payload_len    = out_ff.payload_len;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_byte_index     = out_ff.byte_index;
   assign rsp_last_of_packet = out_ff.last_of_packet;
   assign rsp_registered_hit = out_ff.registered_hit;
   assign rsp_hit_slot       = out_ff.hit_slot;
   assign rsp_to_unknown     = out_ff.to_unknown;
   assign rsp_to_catchall    = out_ff.to_catchall;

endmodule

>>> hdl/rsd_checker.sv
// Port-level checks of the deframer's result channel, bound to the top level.
module rsd_port_assertions (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_prog_id,
   input logic [4:0] rsp_payload_len,
   input logic [4:0] rsp_byte_index,
   input logic       rsp_last_of_packet,
   input logic       rsp_registered_hit,
   input logic [1:0] rsp_hit_slot,
   input logic       rsp_to_unknown,
   input logic       rsp_to_catchall
);
   import rsd_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_prog_id))
      else $error("Stalled result changed before its transfer.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DROP |-> !rsp_registered_hit && !rsp_to_unknown &&
         !rsp_to_catchall && rsp_payload_len == 5'd0 && !rsp_last_of_packet)
      else $error("Drop result carries delivery flags or a length.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_registered_hit |-> !rsp_to_unknown)
      else $error("Registered ID also routed to the unknown-ID consumer.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_registered_hit |-> rsp_hit_slot == 2'd0)
      else $error("Hit slot is set without a registered hit.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD |-> rsp_byte_index < rsp_payload_len &&
         rsp_last_of_packet == (rsp_byte_index + 5'd1 == rsp_payload_len))
      else $error("Payload byte index or last mark is inconsistent with its length.");

endmodule

bind radio_subpacket_deframer rsd_port_assertions u_rsd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_kind          (rsp_kind),
   .rsp_prog_id       (rsp_prog_id),
   .rsp_payload_len   (rsp_payload_len),
   .rsp_byte_index    (rsp_byte_index),
   .rsp_last_of_packet(rsp_last_of_packet),
   .rsp_registered_hit(rsp_registered_hit),
   .rsp_hit_slot      (rsp_hit_slot),
   .rsp_to_unknown    (rsp_to_unknown),
   .rsp_to_catchall   (rsp_to_catchall)
);

>>> sim/rsd_checker.sv
`timescale 1ns / 1ps
// Checker for the radio sub-packet deframer: tracks the slot table, predicts results and compares them.
module rsd_checker
   import rsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   input  logic [5:0]         req_frame_len,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_kind,
   input  logic [7:0]         rsp_prog_id,
   input  logic [4:0]         rsp_payload_len,
   input  logic [7:0]         rsp_payload_byte,
   input  logic [4:0]         rsp_byte_index,
   input  logic               rsp_last_of_packet,
   input  logic               rsp_registered_hit,
   input  logic [1:0]         rsp_hit_slot,
   input  logic               rsp_to_unknown,
   input  logic               rsp_to_catchall,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [7:0]         csr_wdata,
   output int                 fail_count,
   output int                 pending,
   output int                 checked
);

   logic [7:0] slot_tab [NumSlotsDef];
   logic       unknown_en;
   logic       catchall_en;

   phase_type  phase;
   logic [4:0] frame_pos;
   logic [7:0] cur_id;
   logic [4:0] cur_len;
   logic [4:0] pay_cnt;
   logic       dropping;

   result_type expected_q [$];

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] ERROR: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                   checked, name, got, want));
      end
   endtask

   function automatic result_type make_result(input kind_type k, input logic [7:0] id,
                                              input logic [4:0] plen, input logic [7:0] data,
                                              input logic [4:0] idx, input logic last,
                                              input bit routed);
      result_type r;
      r = '0;
      r.kind = k;
      r.prog_id = id;
      r.payload_len = plen;
      r.payload_byte = data;
      r.byte_index = idx;
      r.last_of_packet = last;
      if (routed) begin
         for (int i = NumSlotsDef - 1; i >= 0; i--) begin
            if (slot_tab[i] != PadLow && slot_tab[i] != PadHigh && slot_tab[i] == id) begin
               r.registered_hit = 1'b1;
               r.hit_slot = 2'(i);
            end
         end
         r.to_unknown = !r.registered_hit && unknown_en;
         r.to_catchall = catchall_en;
      end
      return r;
   endfunction

   // Advances the parser by one frame byte; returns 1 when the byte yields a result.
   function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                     input logic [5:0] len_in, output result_type res);
      int  flen;
      int  pos;
      bit  got;
      logic last;
      got = 1'b0;
      res = '0;
      flen = (int'(len_in) > MaxFrameDef) ? MaxFrameDef : int'(len_in);
      if (st) begin
         frame_pos = '0;
         phase = PH_ID;
         dropping = 1'b0;
      end
      if (dropping) begin
         return 1'b0;
      end
      pos = int'(frame_pos);
      if (pos >= flen) begin
         dropping = 1'b1;
         return 1'b0;
      end
      case (phase)
         PH_LEN: begin
            if (pos + int'(b) < flen) begin
               if (b == 8'd0) begin
                  res = make_result(KIND_EMPTY, cur_id, 5'd0, 8'd0, 5'd0, 1'b1, 1'b1);
                  got = 1'b1;
                  phase = PH_ID;
               end else begin
                  cur_len = b[4:0];
                  pay_cnt = '0;
                  phase = PH_DATA;
               end
            end else begin
               res = make_result(KIND_DROP, cur_id, 5'd0, 8'd0, 5'd0, 1'b0, 1'b0);
               got = 1'b1;
               dropping = 1'b1;
            end
         end
         PH_DATA: begin
            last = (int'(pay_cnt) + 1 == int'(cur_len));
            res = make_result(KIND_PAYLOAD, cur_id, cur_len, b, pay_cnt, last, 1'b1);
            got = 1'b1;
            pay_cnt = pay_cnt + 5'd1;
            if (last) begin
               phase = PH_ID;
            end
         end
         default: begin
            phase = PH_ID;
            if (b != PadLow && b != PadHigh) begin
               if (pos + 1 >= flen) begin
                  res = make_result(KIND_DROP, b, 5'd0, 8'd0, 5'd0, 1'b0, 1'b0);
                  got = 1'b1;
                  dropping = 1'b1;
               end else begin
                  cur_id = b;
                  phase = PH_LEN;
               end
            end
         end
      endcase
      if (pos + 1 >= flen) begin
         dropping = 1'b1;
      end
      frame_pos = 5'(pos + 1);
      return got;
   endfunction

   always @(posedge clock) begin : watch
      result_type res;
      result_type want;
      if (reset) begin
         for (int i = 0; i < NumSlotsDef; i++) begin
            slot_tab[i] = PadHigh;
         end
         unknown_en = 1'b0;
         catchall_en = 1'b0;
         phase = PH_ID;
         frame_pos = '0;
         cur_id = '0;
         cur_len = '0;
         pay_cnt = '0;
         dropping = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index < CsrIdxW'(NumSlotsDef)) begin
               slot_tab[csr_index[1:0]] = csr_wdata;
            end else if (csr_index == CSR_UNKNOWN_EN) begin
               unknown_en = csr_wdata[0];
            end else if (csr_index == CSR_CATCHALL_EN) begin
               catchall_en = csr_wdata[0];
            end
         end
         if (req_valid && req_ready) begin
            if (parse_byte(req_rx_byte, req_frame_start, req_frame_len, res)) begin
               expected_q.push_back(res);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
            end else begin
               want = expected_q.pop_front();
               check_field("kind", int'(rsp_kind), int'(want.kind));
               check_field("prog_id", int'(rsp_prog_id), int'(want.prog_id));
               check_field("payload_len", int'(rsp_payload_len), int'(want.payload_len));
               check_field("payload_byte", int'(rsp_payload_byte), int'(want.payload_byte));
               check_field("byte_index", int'(rsp_byte_index), int'(want.byte_index));
               check_field("last_of_packet", int'(rsp_last_of_packet),
                           int'(want.last_of_packet));
               check_field("registered_hit", int'(rsp_registered_hit),
                           int'(want.registered_hit));
               check_field("hit_slot", int'(rsp_hit_slot), int'(want.hit_slot));
               check_field("to_unknown", int'(rsp_to_unknown), int'(want.to_unknown));
               check_field("to_catchall", int'(rsp_to_catchall), int'(want.to_catchall));
            end
            checked++;
         end
      end
      pending = expected_q.size();
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the radio sub-packet deframer: clock, reset, frame stimulus and verdict.
module tb;
   import rsd_pkg::*;

   typedef logic [ByteW-1:0] byte_q_type [$];

   localparam int ClockHalf  = 6;
   localparam int CycleLimit = 300000;
   localparam int PhaseItems = 190;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = '0;
   logic               req_frame_start = 1'b0;
   logic [5:0]         req_frame_len = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_kind;
   logic [7:0]         rsp_prog_id;
   logic [4:0]         rsp_payload_len;
   logic [7:0]         rsp_payload_byte;
   logic [4:0]         rsp_byte_index;
   logic               rsp_last_of_packet;
   logic               rsp_registered_hit;
   logic [1:0]         rsp_hit_slot;
   logic               rsp_to_unknown;
   logic               rsp_to_catchall;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [7:0]         csr_wdata = '0;

   int         fail_count;
   int         pending;
   int         checked;
   int         cycles = 0;
   int         items_sent = 0;
   int         cfg_count = 0;
   int         stall_left = 0;
   bit         gap_en = 1'b0;
   bit         stall_en = 1'b0;
   logic [7:0] cfg_slots [NumSlotsDef];

   radio_subpacket_deframer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_frame_start    (req_frame_start),
      .req_frame_len      (req_frame_len),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_prog_id        (rsp_prog_id),
      .rsp_payload_len    (rsp_payload_len),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_registered_hit (rsp_registered_hit),
      .rsp_hit_slot       (rsp_hit_slot),
      .rsp_to_unknown     (rsp_to_unknown),
      .rsp_to_catchall    (rsp_to_catchall),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   rsd_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_frame_start    (req_frame_start),
      .req_frame_len      (req_frame_len),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_prog_id        (rsp_prog_id),
      .rsp_payload_len    (rsp_payload_len),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_registered_hit (rsp_registered_hit),
      .rsp_hit_slot       (rsp_hit_slot),
      .rsp_to_unknown     (rsp_to_unknown),
      .rsp_to_catchall    (rsp_to_catchall),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending            (pending),
      .checked            (checked)
   );

   always #ClockHalf clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (stall_en && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(1, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [7:0] b, input logic st, input logic [5:0] fl);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_start <= st;
      req_frame_len <= fl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (gap_en && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_config(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] s3, input logic unk, input logic ca);
      cfg_slots[0] = s0;
      cfg_slots[1] = s1;
      cfg_slots[2] = s2;
      cfg_slots[3] = s3;
      for (int i = 0; i < NumSlotsDef; i++) begin
         csr_write(CsrIdxW'(CSR_SLOT0 + i), cfg_slots[i]);
      end
      csr_write(CSR_UNKNOWN_EN, {7'($urandom), unk});
      csr_write(CSR_CATCHALL_EN, {7'($urandom), ca});
      csr_valid <= 1'b0;
      cfg_count++;
   endtask

   // Waits until every predicted result has been taken and the pipeline has settled.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_prog_id();
      if ($urandom_range(0, 99) < 45) begin
         return cfg_slots[$urandom_range(0, NumSlotsDef - 1)];
      end
      return 8'($urandom_range(1, 254));
   endfunction

   function automatic byte_q_type build_frame(input int flen);
      byte_q_type q;
      int         room;
      int         plen;
      q = {};
      if (flen == MaxFrameDef && $urandom_range(0, 3) == 0) begin
         q.push_back(pick_prog_id());
         q.push_back(8'(MaxFrameDef - 2));
         repeat (MaxFrameDef - 2) q.push_back(8'($urandom));
         return q;
      end
      while (q.size() < flen) begin
         if ($urandom_range(0, 99) < 8) begin
            q.push_back($urandom_range(0, 1) ? PadHigh : PadLow);
         end else begin
            q.push_back(pick_prog_id());
            if (q.size() < flen) begin
               room = flen - q.size() - 1;
               if ($urandom_range(0, 99) < 6) begin
                  q.push_back(8'($urandom_range(room + 1, 255)));
                  while (q.size() < flen) q.push_back(8'($urandom));
               end else begin
                  plen = $urandom_range(0, (room < 10) ? room : 10);
                  if ($urandom_range(0, 7) == 0) begin
                     plen = room;
                  end
                  q.push_back(8'(plen));
                  repeat (plen) q.push_back(8'($urandom));
               end
            end
         end
      end
      return q;
   endfunction

   task automatic send_frame(input byte_q_type bytes, input logic [5:0] len_field,
                             input int count, input bit garble, input bit first_start);
      logic [5:0] fl;
      for (int i = 0; i < count; i++) begin
         fl = (garble && $urandom_range(0, 7) == 0) ? 6'($urandom) : len_field;
         send_item(bytes[i], (i == 0) && first_start, fl);
      end
   endtask

   task automatic run_traffic(input int target, input bit idle);
      byte_q_type q;
      int         flen;
      int         cut;
      int         stop;
      logic [5:0] field;
      stop = items_sent + target;
      while (items_sent < stop) begin
         gap_en = idle && $urandom_range(0, 3) != 0;
         stall_en = idle && $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'($urandom), 6'($urandom));
         end else begin
            flen = ($urandom_range(0, 5) == 0) ? MaxFrameDef : $urandom_range(1, MaxFrameDef);
            q = build_frame(flen);
            field = 6'(flen);
            if (flen == MaxFrameDef && $urandom_range(0, 2) == 0) begin
               field = 6'($urandom_range(MaxFrameDef + 1, 63));
            end
            cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, flen) : flen;
            send_frame(q, field, cut, $urandom_range(0, 24) == 0, 1'b1);
            if ($urandom_range(0, 14) == 0) begin
               repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0, field);
            end
         end
      end
   endtask

   initial begin
      byte_q_type frame;
      logic [7:0] s;
      for (int i = 0; i < NumSlotsDef; i++) begin
         cfg_slots[i] = PadHigh;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Duplicate registered IDs check that the lowest slot wins.
      load_config(8'h11, 8'h22, 8'h11, PadHigh, 1'b1, 1'b1);
      frame = {PadLow, 8'h22, 8'h02, PadLow, PadHigh, 8'h33, PadLow};
      send_frame(frame, 6'd7, 7, 1'b0, 1'b0);
      frame = {8'h11, 8'h05, 8'h7E};
      send_frame(frame, 6'd3, 3, 1'b0, 1'b1);
      frame = {PadHigh, 8'h44};
      send_frame(frame, 6'd2, 2, 1'b0, 1'b1);
      frame = {8'h5A, 8'h11};
      send_frame(frame, 6'd0, 2, 1'b0, 1'b1);
      frame = {8'h11, 8'h01, 8'h80};
      send_frame(frame, 6'd3, 3, 1'b0, 1'b1);
      send_item(8'hC3, 1'b0, 6'd3);
      frame = {8'h22, 8'h00, PadLow};
      send_frame(frame, 6'd63, 3, 1'b0, 1'b1);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               load_config(PadLow, PadHigh, 8'h01, 8'hFE, 1'b0, 1'b0);
            end
            1: begin
               load_config(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)),
                           8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)), 1'b1, 1'b0);
            end
            2: begin
               s = 8'($urandom_range(1, 254));
               load_config(s, s, s, s, 1'b0, 1'b1);
            end
            3: begin
               for (int k = CSR_CATCHALL_EN + 1; k < 2 ** CsrIdxW; k++) begin
                  csr_write(CsrIdxW'(k), 8'($urandom));
               end
               load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           1'($urandom), 1'($urandom));
            end
            default: begin
               load_config(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)),
                           8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)), 1'b1, 1'b1);
            end
         endcase
         run_traffic(PhaseItems, ph != 4);
         gap_en = 1'b0;
         stall_en = 1'b0;
         drain();
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      $display("Sent %0d frame bytes under %0d slot-table settings; %0d results compared.",
               items_sent, cfg_count, checked);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
